FILE: rtl/pc_sample_region_profiler_assert.svh
// Assertion shorthands for the checker file.
`ifndef PC_SAMPLE_REGION_PROFILER_ASSERT_SVH
`define PC_SAMPLE_REGION_PROFILER_ASSERT_SVH

// Check on every clock edge outside reset.
`define PCSRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define PCSRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/pcsrp_pkg.sv
`default_nettype none

package pcsrp_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ACT_W       = 7;
    localparam int RIDX_W      = 6;
    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int CMP_W       = ((IDX_W > ACT_W) ? IDX_W : ACT_W) + 1;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    typedef enum logic {
        REG_ENABLE = 1'b0,
        REG_ACTIVE = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [RIDX_W-1:0]  region_index;
        logic [ADDR_W-1:0]  region_first;
        logic [ADDR_W-1:0]  region_last;
        logic [ADDR_W-1:0]  sample_pc;
    } t_in_item;

    typedef struct packed {
        logic               matched;
        logic [RIDX_W-1:0]  matched_region;
        logic [CNT_W-1:0]   region_hits;
        logic [CNT_W-1:0]   total_samples;
        logic [CNT_W-1:0]   lost_samples;
        logic [ADDR_W-1:0]  last_lost_pc;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  pc;
        logic               found;
        logic [IDX_W-1:0]   hit_idx;
        logic [CNT_W-1:0]   hits;
    } t_token;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   index;
        logic [ADDR_W-1:0]  first;
        logic [ADDR_W-1:0]  last;
    } t_wr;

endpackage

`default_nettype wire

FILE: rtl/pcsrp_if.sv
`default_nettype none

interface pcsrp_in_if;
    logic                 valid;
    logic                 ready;
    pcsrp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcsrp_out_if;
    logic                  valid;
    logic                  ready;
    pcsrp_pkg::t_out_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pcsrp_cell.sv
`default_nettype none

module pcsrp_cell (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [pcsrp_pkg::IDX_W-1:0]     i_index,
    input  wire logic [pcsrp_pkg::ACT_W-1:0]     i_active,
    input  wire pcsrp_pkg::t_wr                  i_wr,
    input  wire pcsrp_pkg::t_token               i_tok,
    output pcsrp_pkg::t_token                    o_tok
);

    logic [pcsrp_pkg::ADDR_W-1:0] r_start;
    logic [pcsrp_pkg::ADDR_W-1:0] r_end;
    logic [pcsrp_pkg::CNT_W-1:0]  r_count;
    logic [pcsrp_pkg::CNT_W-1:0]  n_count;
    pcsrp_pkg::t_token            r_tok;
    pcsrp_pkg::t_token            n_tok;
    logic                         w_in_use;
    logic                         w_hit;

    assign w_in_use = pcsrp_pkg::CMP_W'(i_index) < pcsrp_pkg::CMP_W'(i_active);
    assign w_hit    = i_tok.valid && !i_tok.found && w_in_use &&
                      (i_tok.pc >= r_start) && (i_tok.pc <= r_end);

    always_comb begin
        n_tok   = i_tok;
        n_count = r_count;
        if (w_hit) begin
            n_count       = r_count + pcsrp_pkg::CNT_W'(1);
            n_tok.found   = 1'b1;
            n_tok.hit_idx = i_index;
            n_tok.hits    = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_tok   <= '0;
        end else begin
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    // load the region bounds
    always_ff @(posedge i_clk) begin
        if (i_wr.valid && (i_wr.index == i_index)) begin
            r_start <= i_wr.first;
            r_end   <= i_wr.last;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: rtl/pc_sample_region_profiler.sv
// Sampling profiler histogram over a table of MAX_REGIONS address regions, each held in
// one cell of a chain together with its hit counter. A region write goes straight into
// its cell; an enabled sample travels down the chain one cell per clock, the first cell
// whose inclusive range holds the address (among the first active_regions) counts the
// hit, and the result leaves the end of the chain. A sample goes from ST_IDLE to ST_SCAN
// for the walk, then ST_HOLD; region writes and samples while disabled go straight to
// ST_HOLD, which waits for a free output register. One item is in work at a time, and
// the output register holds a result while the next item is taken. Hit counters clear
// at reset with no clearing pass; region bounds must be written before they are searched.
// Registers: profile_enable at byte 0, active_regions at byte 4.
`default_nettype none

module pc_sample_region_profiler (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    pcsrp_in_if.sink                              i_in,
    pcsrp_out_if.source                           o_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pcsrp_pkg::APB_AW-1:0]     paddr,
    input  wire logic [pcsrp_pkg::APB_DW-1:0]     pwdata,
    output logic      [pcsrp_pkg::APB_DW-1:0]     prdata,
    output logic                                  pready
);

    localparam int N = pcsrp_pkg::MAX_REGIONS;

    pcsrp_pkg::t_state               r_state;
    pcsrp_pkg::t_state               n_state;
    logic                            r_enable;
    logic [pcsrp_pkg::ACT_W-1:0]     r_active;
    logic [pcsrp_pkg::CNT_W-1:0]     r_total;
    logic [pcsrp_pkg::CNT_W-1:0]     n_total;
    logic [pcsrp_pkg::CNT_W-1:0]     r_lost;
    logic [pcsrp_pkg::CNT_W-1:0]     n_lost;
    logic [pcsrp_pkg::ADDR_W-1:0]    r_lost_pc;
    logic [pcsrp_pkg::ADDR_W-1:0]    n_lost_pc;
    pcsrp_pkg::t_out_item            r_res;
    pcsrp_pkg::t_out_item            n_res;
    pcsrp_pkg::t_out_item            r_out;
    pcsrp_pkg::t_out_item            n_out;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            w_in_ready;
    logic                            w_cfg_wr;
    pcsrp_pkg::t_reg_idx             w_reg;
    pcsrp_pkg::t_wr                  w_wr;
    pcsrp_pkg::t_token               w_head;
    pcsrp_pkg::t_token               w_chain [N+1];
    pcsrp_pkg::t_token               w_tail;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = pcsrp_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_active <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg)
                pcsrp_pkg::REG_ENABLE: r_enable <= pwdata[0];
                pcsrp_pkg::REG_ACTIVE: r_active <= pwdata[pcsrp_pkg::ACT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            pcsrp_pkg::REG_ENABLE: prdata = pcsrp_pkg::APB_DW'(r_enable);
            pcsrp_pkg::REG_ACTIVE: prdata = pcsrp_pkg::APB_DW'(r_active);
        endcase
    end

    assign w_chain[0] = w_head;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            pcsrp_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_index  (pcsrp_pkg::IDX_W'(gi)),
                .i_active (r_active),
                .i_wr     (w_wr),
                .i_tok    (w_chain[gi]),
                .o_tok    (w_chain[gi+1])
            );
        end
    endgenerate

    assign w_tail = w_chain[N];

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_lost      = r_lost;
        n_lost_pc   = r_lost_pc;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_in_ready  = 1'b0;
        w_wr        = '0;
        w_head      = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pcsrp_pkg::ST_IDLE: begin
                w_in_ready                = 1'b1;
                n_res.matched             = 1'b0;
                n_res.matched_region      = '0;
                n_res.region_hits         = '0;
                n_res.total_samples       = r_total;
                n_res.lost_samples        = r_lost;
                n_res.last_lost_pc        = r_lost_pc;
                if (i_in.valid) begin
                    priority if (i_in.data.operation == pcsrp_pkg::OP_WRITE) begin
                        w_wr.valid = pcsrp_pkg::CMP_W'(i_in.data.region_index) <
                                     pcsrp_pkg::CMP_W'(N);
                        w_wr.index = pcsrp_pkg::IDX_W'(i_in.data.region_index);
                        w_wr.first = i_in.data.region_first;
                        w_wr.last  = i_in.data.region_last;
                        n_state    = pcsrp_pkg::ST_HOLD;
                    end else if (r_enable) begin
                        n_total      = r_total + pcsrp_pkg::CNT_W'(1);
                        w_head.valid = 1'b1;
                        w_head.pc    = i_in.data.sample_pc;
                        n_state      = pcsrp_pkg::ST_SCAN;
                    end else begin
                        n_state = pcsrp_pkg::ST_HOLD;
                    end
                end
            end
            pcsrp_pkg::ST_SCAN: begin
                if (w_tail.valid) begin
                    n_res.total_samples = r_total;
                    if (w_tail.found) begin
                        n_res.matched        = 1'b1;
                        n_res.matched_region = pcsrp_pkg::RIDX_W'(w_tail.hit_idx);
                        n_res.region_hits    = w_tail.hits;
                        n_res.lost_samples   = r_lost;
                        n_res.last_lost_pc   = r_lost_pc;
                    end else begin
                        n_lost               = r_lost + pcsrp_pkg::CNT_W'(1);
                        n_lost_pc            = w_tail.pc;
                        n_res.matched        = 1'b0;
                        n_res.matched_region = '0;
                        n_res.region_hits    = '0;
                        n_res.lost_samples   = n_lost;
                        n_res.last_lost_pc   = n_lost_pc;
                    end
                    n_state = pcsrp_pkg::ST_HOLD;
                end
            end
            pcsrp_pkg::ST_HOLD: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = pcsrp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcsrp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcsrp_pkg::ST_IDLE;
            r_total     <= '0;
            r_lost      <= '0;
            r_lost_pc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_lost      <= n_lost;
            r_lost_pc   <= n_lost_pc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/pcsrp_checker.sv
`default_nettype none

`include "pc_sample_region_profiler_assert.svh"

module pcsrp_checker (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  i_in_ready,
    input wire logic                  i_out_valid,
    input wire logic                  i_out_ready,
    input wire pcsrp_pkg::t_out_item  i_out_data
);

    `PCSRP_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")
    `PCSRP_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_data), "result moved")
    `PCSRP_ASSERT(a_one_item, i_in_valid && i_in_ready |=> !i_in_ready, "second item taken")
    `PCSRP_ASSERT(a_miss_zero, i_out_valid && !i_out_data.matched |-> (i_out_data.matched_region == '0) && (i_out_data.region_hits == '0), "miss carries hit data")
    `PCSRP_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind pc_sample_region_profiler pcsrp_checker u_pcsrp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire

FILE: sim/tb_pc_sample_region_profiler.sv
`default_nettype none

module tb_pc_sample_region_profiler;
    timeunit 1ns;
    timeprecision 1ps;

    import pcsrp_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic i_clk;
    logic i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    pcsrp_in_if  in_ch ();
    pcsrp_out_if out_ch ();

    pc_sample_region_profiler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // profiler image: region table, hit counters, global counters, registers
    bit [ADDR_W-1:0] bound_lo [MAX_REGIONS];
    bit [ADDR_W-1:0] bound_hi [MAX_REGIONS];
    bit [CNT_W-1:0]  hit_tally [MAX_REGIONS];
    bit [CNT_W-1:0]  sample_count;
    bit [CNT_W-1:0]  miss_count;
    bit [ADDR_W-1:0] miss_pc;
    bit              cfg_enable;
    bit [ACT_W-1:0]  cfg_active;

    t_out_item tally_queue [$];

    int fault_count;
    int cycle_count;
    int burst_left;
    bit bursty_source;
    int sink_stall_pct;
    int sink_hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_pc_sample_region_profiler: done, errors");
        $finish;
    end

    // receiver: stall runs at a per-phase rate, or one long hold on request
    initial begin
        int stall_left;
        int hold_len;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles > 0) begin
                hold_len = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_ch.ready = 1'b0;
                repeat (hold_len - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 99) < sink_stall_pct) begin
                out_ch.ready = 1'b0;
                stall_left = $urandom_range(0, 5);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    function automatic t_out_item profile_item(t_in_item it);
        t_out_item res;
        int        limit;
        int        i;
        res = '0;
        if (it.operation == OP_WRITE) begin
            bound_lo[it.region_index] = it.region_first;
            bound_hi[it.region_index] = it.region_last;
        end else if (cfg_enable) begin
            limit = (cfg_active > MAX_REGIONS) ? MAX_REGIONS : int'(cfg_active);
            sample_count++;
            for (i = 0; i < limit; i++) begin
                if (!res.matched && it.sample_pc >= bound_lo[i]
                        && it.sample_pc <= bound_hi[i]) begin
                    hit_tally[i]++;
                    res.matched        = 1'b1;
                    res.matched_region = RIDX_W'(i);
                    res.region_hits    = hit_tally[i];
                end
            end
            if (!res.matched) begin
                miss_pc = it.sample_pc;
                miss_count++;
            end
        end
        res.total_samples = sample_count;
        res.lost_samples  = miss_count;
        res.last_lost_pc  = miss_pc;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fault_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
            if (tally_queue.size() == 0) begin
                $error("result transfer with nothing expected");
                fault_count++;
            end else begin
                want = tally_queue.pop_front();
                check_field("matched", want.matched, out_ch.data.matched);
                check_field("matched_region", want.matched_region,
                            out_ch.data.matched_region);
                check_field("region_hits", want.region_hits, out_ch.data.region_hits);
                check_field("total_samples", want.total_samples,
                            out_ch.data.total_samples);
                check_field("lost_samples", want.lost_samples, out_ch.data.lost_samples);
                check_field("last_lost_pc", want.last_lost_pc, out_ch.data.last_lost_pc);
            end
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        if (bursty_source && burst_left == 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        in_ch.data  = it;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        tally_queue.push_back(profile_item(it));
        if (burst_left > 0) burst_left--;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (tally_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_register(t_reg_idx which, logic [31:0] value);
        logic [31:0] readback;
        drain_results();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {which, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (which == REG_ENABLE) cfg_enable = value[0];
        else cfg_active = value[ACT_W-1:0];
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (which == REG_ENABLE) check_field("prdata profile_enable", cfg_enable, readback[0]);
        else check_field("prdata active_regions", cfg_active, readback[ACT_W-1:0]);
    endtask

    function automatic t_in_item region_write(int idx, logic [31:0] first,
                                              logic [31:0] last);
        t_in_item it;
        it.operation    = OP_WRITE;
        it.region_index = RIDX_W'(idx);
        it.region_first = first;
        it.region_last  = last;
        it.sample_pc    = $urandom;
        return it;
    endfunction

    function automatic t_in_item pc_sample(logic [31:0] pc);
        t_in_item it;
        it.operation    = OP_SAMPLE;
        it.region_index = RIDX_W'($urandom_range(0, 63));
        it.region_first = $urandom;
        it.region_last  = $urandom;
        it.sample_pc    = pc;
        return it;
    endfunction

    function automatic t_in_item random_region_write(int idx);
        logic [31:0] a;
        logic [31:0] b;
        int          pick;
        a    = $urandom;
        b    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 5) return region_write(idx, (a > b) ? a : b, (a > b) ? b : a);
        if (pick < 6) return region_write(idx, 32'h0, 32'hFFFF_FFFF);
        if (pick < 14) return region_write(idx, a, a);
        return region_write(idx, a, a + $urandom_range(0, 65535));
    endfunction

    function automatic t_in_item random_sample();
        int          eff;
        int          j;
        int          pick;
        logic [31:0] lo;
        logic [31:0] hi;
        eff  = (cfg_active > MAX_REGIONS) ? MAX_REGIONS : int'(cfg_active);
        j    = (eff == 0) ? $urandom_range(0, MAX_REGIONS - 1) : $urandom_range(0, eff - 1);
        lo   = bound_lo[j];
        hi   = bound_hi[j];
        pick = $urandom_range(0, 99);
        if (pick < 65 && lo <= hi) return pc_sample(lo + $urandom_range(0, hi - lo));
        if (pick < 80) begin
            case ($urandom_range(0, 3))
                0: return pc_sample(lo);
                1: return pc_sample(hi);
                2: return pc_sample(lo - 1);
                default: return pc_sample(hi + 1);
            endcase
        end
        return pc_sample($urandom);
    endfunction

    task automatic test_disabled_samples();
        set_register(REG_ENABLE, 0);
        set_register(REG_ACTIVE, 0);
        send_item(pc_sample(32'h0000_0000));
        send_item(pc_sample(32'hFFFF_FFFF));
        send_item(region_write(0, 32'h0000_0010, 32'h0000_0005));
        send_item(region_write(1, 32'h0000_0100, 32'h0000_01FF));
        send_item(region_write(2, 32'h0000_0180, 32'h0000_0280));
        send_item(region_write(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(region_write(63, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(pc_sample(32'h0000_0150));
    endtask

    task automatic test_region_search();
        set_register(REG_ENABLE, 1);
        send_item(pc_sample(32'h0000_0150));
        set_register(REG_ACTIVE, 2);
        send_item(pc_sample(32'h0000_0150));
        send_item(pc_sample(32'h0000_0008));
        send_item(pc_sample(32'h0000_0250));
        set_register(REG_ACTIVE, 4);
        send_item(pc_sample(32'h0000_0190));
        send_item(pc_sample(32'h0000_0250));
        send_item(pc_sample(32'hFFFF_FFFF));
        send_item(pc_sample(32'h0000_0000));
        send_item(pc_sample(32'h0000_01FF));
        send_item(pc_sample(32'h0000_0100));
        send_item(pc_sample(32'h0000_00FF));
        send_item(region_write(1, 32'h0000_0000, 32'h0000_0000));
        send_item(pc_sample(32'h0000_0000));
        send_item(pc_sample(32'h0000_0150));
    endtask

    task automatic test_enable_toggle();
        set_register(REG_ENABLE, 0);
        send_item(pc_sample(32'h0000_0190));
        set_register(REG_ENABLE, 1);
        send_item(pc_sample(32'h0000_0000));
    endtask

    task automatic test_table_fill();
        int idx;
        for (idx = 0; idx < MAX_REGIONS; idx++) send_item(random_region_write(idx));
    endtask

    task automatic test_random_traffic();
        bit en_sel    [7] = '{1, 1, 1, 0, 1, 1, 1};
        int act_sel   [7] = '{64, 1, -1, 64, 127, 0, -1};
        int num_sel   [7] = '{300, 250, 300, 60, 300, 200, 350};
        bit burst_sel [7] = '{1, 0, 1, 1, 1, 0, 1};
        int stall_sel [7] = '{30, 0, 60, 20, 10, 40, 25};
        int ph;
        int act;
        for (ph = 0; ph < 7; ph++) begin
            act = (act_sel[ph] < 0) ? $urandom_range(2, 63) : act_sel[ph];
            set_register(REG_ENABLE, en_sel[ph]);
            set_register(REG_ACTIVE, act);
            bursty_source  = burst_sel[ph];
            sink_stall_pct = stall_sel[ph];
            repeat (num_sel[ph]) begin
                if ($urandom_range(0, 3) == 0)
                    send_item(random_region_write($urandom_range(0, MAX_REGIONS - 1)));
                else
                    send_item(random_sample());
            end
        end
    endtask

    task automatic test_backpressure();
        set_register(REG_ENABLE, 1);
        set_register(REG_ACTIVE, 64);
        bursty_source    = 1'b0;
        sink_stall_pct   = 0;
        sink_hold_cycles = 400;
        repeat (60) begin
            if ($urandom_range(0, 4) == 0)
                send_item(random_region_write($urandom_range(0, MAX_REGIONS - 1)));
            else
                send_item(random_sample());
        end
        drain_results();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        fault_count      = 0;
        cycle_count      = 0;
        burst_left       = 0;
        bursty_source    = 1'b1;
        sink_stall_pct   = 20;
        sink_hold_cycles = 0;
        sample_count     = '0;
        miss_count       = '0;
        miss_pc          = '0;
        cfg_enable       = 1'b0;
        cfg_active       = '0;
        foreach (hit_tally[k]) begin
            hit_tally[k] = '0;
            bound_lo[k]  = '0;
            bound_hi[k]  = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled_samples();
        test_region_search();
        test_enable_toggle();
        test_table_fill();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fault_count == 0 && tally_queue.size() == 0) begin
            $display("tb_pc_sample_region_profiler: done, clean");
        end else begin
            $display("tb_pc_sample_region_profiler: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
